/* sv/apc_pkg.sv */
// shared constants and types for the action potential characteriser
`default_nettype none
package apc_pkg;

	// default field widths
	localparam int VOLT_WIDTH_DEF  = 16;
	localparam int SLOPE_WIDTH_DEF = 24;
	localparam int TIME_WIDTH_DEF  = 32;

	// 0.1 in q0.16, applied as multiply then arithmetic shift
	localparam int TENTH_W     = 13;
	localparam logic [TENTH_W-1:0] TENTH_Q16 = 13'd6554;
	localparam int FRAC_SHIFT  = 16;

	// repolarisation progress within one beat
	typedef enum logic [1:0] {
		REPOL_WAIT50 = 2'd0,
		REPOL_WAIT90 = 2'd1,
		REPOL_DONE   = 2'd2
	} repol_stage_t;

endpackage : apc_pkg
`default_nettype wire

/* sv/action_potential_characterizer_unit.sv */
// top level of the action potential characteriser (apd50 / apd90)
// an input transfer fills the stage 1 register; a step moves it to the result register on m_*
// throughput: one sample per cycle, sustained, while the master side keeps m_tready high
// the rate is set by the single-pass step logic: peak detect, threshold multiply and compares
// reset: arst_n clears both stage valids and all beat state; peak counts as found until an onset
`default_nettype none
module action_potential_characterizer_unit #(
	parameter int VOLT_WIDTH  = apc_pkg::VOLT_WIDTH_DEF,
	parameter int SLOPE_WIDTH = apc_pkg::SLOPE_WIDTH_DEF,
	parameter int TIME_WIDTH  = apc_pkg::TIME_WIDTH_DEF,
	localparam int S_DATA_W = ((VOLT_WIDTH + SLOPE_WIDTH + TIME_WIDTH + 7) / 8) * 8,
	localparam int M_DATA_W = ((SLOPE_WIDTH + 2 * VOLT_WIDTH + 2 * TIME_WIDTH + 7) / 8) * 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// voltage, slope, sample_time (from bit 0 up), zero padded to bytes
	input  wire logic [S_DATA_W-1:0] s_tdata,
	// stim_active
	input  wire logic                s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// max_upstroke_out, rest_out, peak_out, apd50_out, apd90_out (from bit 0 up), zero padded
	output logic [M_DATA_W-1:0]      m_tdata
);
	import apc_pkg::*;

	// stage 1 holding register
	logic                          valid_s1;
	logic                          stim_s1;
	logic signed [VOLT_WIDTH-1:0]  volt_s1;
	logic signed [SLOPE_WIDTH-1:0] slope_s1;
	logic [TIME_WIDTH-1:0]         time_s1;

	// step results
	logic signed [SLOPE_WIDTH-1:0] max_up;
	logic signed [VOLT_WIDTH-1:0]  rest;
	logic signed [VOLT_WIDTH-1:0]  peak;
	logic [TIME_WIDTH-1:0]         apd50;
	logic [TIME_WIDTH-1:0]         apd90;

	logic out_free;
	logic step;

	// a sample is processed (and beat state moves) exactly when it moves into the result register
	assign step = valid_s1 && out_free;

	apc_in_stage #(
		.VOLT_WIDTH (VOLT_WIDTH),
		.SLOPE_WIDTH(SLOPE_WIDTH),
		.TIME_WIDTH (TIME_WIDTH)
	) u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.adv     (out_free),
		.valid_s1(valid_s1),
		.stim_s1 (stim_s1),
		.volt_s1 (volt_s1),
		.slope_s1(slope_s1),
		.time_s1 (time_s1)
	);

	// beat state: rest latch on onset, upstroke max, peak, repolarisation timing
	apc_core #(
		.VOLT_WIDTH (VOLT_WIDTH),
		.SLOPE_WIDTH(SLOPE_WIDTH),
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.stim  (stim_s1),
		.volt  (volt_s1),
		.slope (slope_s1),
		.stime (time_s1),
		.max_up(max_up),
		.rest  (rest),
		.peak  (peak),
		.apd50 (apd50),
		.apd90 (apd90)
	);

	// result register parts the master side from the step logic
	apc_out_stage #(
		.VOLT_WIDTH (VOLT_WIDTH),
		.SLOPE_WIDTH(SLOPE_WIDTH),
		.TIME_WIDTH (TIME_WIDTH)
	) u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (step),
		.max_up  (max_up),
		.rest    (rest),
		.peak    (peak),
		.apd50   (apd50),
		.apd90   (apd90),
		.out_free(out_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule : action_potential_characterizer_unit
`default_nettype wire

/* sv/apc_in_stage.sv */
// input register stage: captures one sample per transfer
`default_nettype none
module apc_in_stage #(
	parameter int VOLT_WIDTH  = apc_pkg::VOLT_WIDTH_DEF,
	parameter int SLOPE_WIDTH = apc_pkg::SLOPE_WIDTH_DEF,
	parameter int TIME_WIDTH  = apc_pkg::TIME_WIDTH_DEF,
	localparam int DATA_W = ((VOLT_WIDTH + SLOPE_WIDTH + TIME_WIDTH + 7) / 8) * 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [DATA_W-1:0]             s_tdata,
	input  wire logic                          s_tuser,
	input  wire logic                          adv,
	output logic                               valid_s1,
	output logic                               stim_s1,
	output logic signed [VOLT_WIDTH-1:0]       volt_s1,
	output logic signed [SLOPE_WIDTH-1:0]      slope_s1,
	output logic [TIME_WIDTH-1:0]              time_s1
);
	import apc_pkg::*;

	logic accept;

	assign s_tready = !valid_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stim_s1  <= s_tuser;
			volt_s1  <= s_tdata[VOLT_WIDTH-1:0];
			slope_s1 <= s_tdata[VOLT_WIDTH +: SLOPE_WIDTH];
			time_s1  <= s_tdata[VOLT_WIDTH+SLOPE_WIDTH +: TIME_WIDTH];
		end
	end

endmodule : apc_in_stage
`default_nettype wire

/* sv/apc_core.sv */
// per-beat state and single-pass step logic
`default_nettype none
module apc_core #(
	parameter int VOLT_WIDTH  = apc_pkg::VOLT_WIDTH_DEF,
	parameter int SLOPE_WIDTH = apc_pkg::SLOPE_WIDTH_DEF,
	parameter int TIME_WIDTH  = apc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic                          stim,
	input  wire logic signed [VOLT_WIDTH-1:0]  volt,
	input  wire logic signed [SLOPE_WIDTH-1:0] slope,
	input  wire logic [TIME_WIDTH-1:0]         stime,
	output logic signed [SLOPE_WIDTH-1:0]      max_up,
	output logic signed [VOLT_WIDTH-1:0]       rest,
	output logic signed [VOLT_WIDTH-1:0]       peak,
	output logic [TIME_WIDTH-1:0]              apd50,
	output logic [TIME_WIDTH-1:0]              apd90
);
	import apc_pkg::*;

	localparam int AMP_W  = VOLT_WIDTH + 1;
	localparam int TH_W   = VOLT_WIDTH + 2;
	localparam int PROD_W = AMP_W + TENTH_W + 1;

	// state registers
	logic                          stim_was_on_q;
	logic                          peak_found_q;
	repol_stage_t                  stage_q;
	logic signed [VOLT_WIDTH-1:0]  prev_volt_q;
	logic signed [SLOPE_WIDTH-1:0] prev_slope_q;
	logic signed [VOLT_WIDTH-1:0]  rest_q;
	logic signed [VOLT_WIDTH-1:0]  peak_q;
	logic signed [SLOPE_WIDTH-1:0] mx_now_q;
	logic signed [SLOPE_WIDTH-1:0] mx_before_q;
	logic [TIME_WIDTH-1:0]         onset_q;
	logic [TIME_WIDTH-1:0]         apd50_q;
	logic [TIME_WIDTH-1:0]         apd90_q;

	// next-state values
	logic                          onset_edge;
	logic                          peak_found_a;
	logic                          peak_hit;
	logic                          peak_found_n;
	repol_stage_t                  stage_a;
	repol_stage_t                  stage_mid;
	repol_stage_t                  stage_n;
	logic signed [VOLT_WIDTH-1:0]  rest_a;
	logic signed [VOLT_WIDTH-1:0]  peak_n;
	logic signed [SLOPE_WIDTH-1:0] mx_now_a;
	logic signed [SLOPE_WIDTH-1:0] mx_now_n;
	logic signed [SLOPE_WIDTH-1:0] mx_before_a;
	logic [TIME_WIDTH-1:0]         onset_a;
	logic [TIME_WIDTH-1:0]         dur;
	logic [TIME_WIDTH-1:0]         apd50_n;
	logic [TIME_WIDTH-1:0]         apd90_n;
	logic signed [AMP_W-1:0]       amp;
	logic signed [PROD_W-1:0]      prod;
	logic signed [TH_W-1:0]        th50;
	logic signed [TH_W-1:0]        th10;
	logic signed [TH_W-1:0]        volt_x;
	logic                          measure;
	logic                          cross50;
	logic                          cross90;

	always_comb begin
		onset_edge   = stim && !stim_was_on_q;
		peak_found_a = onset_edge ? 1'b0 : peak_found_q;
		stage_a      = onset_edge ? REPOL_WAIT50 : stage_q;
		rest_a       = onset_edge ? prev_volt_q : rest_q;
		onset_a      = onset_edge ? stime : onset_q;
		mx_before_a  = onset_edge ? mx_now_q : mx_before_q;
		mx_now_a     = onset_edge ? slope : mx_now_q;

		max_up   = peak_found_a ? mx_now_a : mx_before_a;
		mx_now_n = (!peak_found_a && (slope > mx_now_a)) ? slope : mx_now_a;

		// slope goes negative from non-negative: that sample is the peak
		peak_hit     = !peak_found_a && slope[SLOPE_WIDTH-1] && !prev_slope_q[SLOPE_WIDTH-1];
		peak_found_n = peak_found_a || peak_hit;
		peak_n       = peak_hit ? volt : peak_q;

		// thresholds above rest, floored
		amp    = AMP_W'(peak_n) - AMP_W'(rest_a);
		prod   = PROD_W'(amp) * $signed({1'b0, TENTH_Q16});
		th50   = TH_W'(rest_a) + TH_W'(amp >>> 1);
		th10   = TH_W'(rest_a) + TH_W'(prod >>> FRAC_SHIFT);
		volt_x = TH_W'(volt);

		measure = !stim && peak_found_n;
		dur     = stime - onset_a;

		cross50   = measure && (volt_x <= th50) && (stage_a == REPOL_WAIT50);
		stage_mid = cross50 ? REPOL_WAIT90 : stage_a;
		cross90   = measure && (volt_x <= th10) && (stage_mid == REPOL_WAIT90);
		stage_n   = cross90 ? REPOL_DONE : stage_mid;
		apd50_n   = cross50 ? dur : apd50_q;
		apd90_n   = cross90 ? dur : apd90_q;

		rest  = rest_a;
		peak  = peak_n;
		apd50 = apd50_n;
		apd90 = apd90_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stim_was_on_q <= 1'b0;
			peak_found_q  <= 1'b1;
			stage_q       <= REPOL_WAIT50;
			prev_volt_q   <= '0;
			prev_slope_q  <= '0;
			rest_q        <= '0;
			peak_q        <= '0;
			mx_now_q      <= '0;
			mx_before_q   <= '0;
			onset_q       <= '0;
			apd50_q       <= '0;
			apd90_q       <= '0;
		end else if (step) begin
			stim_was_on_q <= stim;
			peak_found_q  <= peak_found_n;
			stage_q       <= stage_n;
			prev_volt_q   <= volt;
			prev_slope_q  <= slope;
			rest_q        <= rest_a;
			peak_q        <= peak_n;
			mx_now_q      <= mx_now_n;
			mx_before_q   <= mx_before_a;
			onset_q       <= onset_a;
			apd50_q       <= apd50_n;
			apd90_q       <= apd90_n;
		end
	end

endmodule : apc_core
`default_nettype wire

/* sv/apc_out_stage.sv */
// result register driving the master-side stream
`default_nettype none
module apc_out_stage #(
	parameter int VOLT_WIDTH  = apc_pkg::VOLT_WIDTH_DEF,
	parameter int SLOPE_WIDTH = apc_pkg::SLOPE_WIDTH_DEF,
	parameter int TIME_WIDTH  = apc_pkg::TIME_WIDTH_DEF,
	localparam int RES_W  = SLOPE_WIDTH + 2 * VOLT_WIDTH + 2 * TIME_WIDTH,
	localparam int DATA_W = ((RES_W + 7) / 8) * 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire logic signed [SLOPE_WIDTH-1:0] max_up,
	input  wire logic signed [VOLT_WIDTH-1:0]  rest,
	input  wire logic signed [VOLT_WIDTH-1:0]  peak,
	input  wire logic [TIME_WIDTH-1:0]         apd50,
	input  wire logic [TIME_WIDTH-1:0]         apd90,
	output logic                               out_free,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [DATA_W-1:0]                  m_tdata
);
	import apc_pkg::*;

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= DATA_W'({apd90, apd50, peak, rest, max_up});
		end
	end

endmodule : apc_out_stage
`default_nettype wire

/* sv/apc_checker.sv */
// port-level checks for the action potential characteriser, bound to the top level
`default_nettype none
module apc_checker #(
	parameter int VOLT_WIDTH  = apc_pkg::VOLT_WIDTH_DEF,
	parameter int SLOPE_WIDTH = apc_pkg::SLOPE_WIDTH_DEF,
	parameter int TIME_WIDTH  = apc_pkg::TIME_WIDTH_DEF,
	localparam int RES_W    = SLOPE_WIDTH + 2 * VOLT_WIDTH + 2 * TIME_WIDTH,
	localparam int M_DATA_W = ((RES_W + 7) / 8) * 8
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata
);
	import apc_pkg::*;

	logic [M_DATA_W:0] pad_chk;

	// pad bits of m_tdata, widened so an unpadded result width still compares
	assign pad_chk = {1'b0, m_tdata} >> RES_W;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	// an empty result register never stalls the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// a fresh result follows an earlier input transfer, passed on through the stage 1 register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without matching input transfer");

	// pad bits are zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pad_chk == '0)
		else $error("non-zero pad bits in result");

endmodule : apc_checker

bind action_potential_characterizer_unit apc_checker #(
	.VOLT_WIDTH (VOLT_WIDTH),
	.SLOPE_WIDTH(SLOPE_WIDTH),
	.TIME_WIDTH (TIME_WIDTH)
) u_apc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire
